>>> rtl/core/mlbc_pkg.sv
`timescale 1ns / 1ps

package mlbc_pkg;

	// Build constants.
	localparam int NUM_LEDS   = 10;
	localparam int FRAME_BITS = 24;
	localparam int LED_W      = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam int SLOT_BITS  = 2 * NUM_LEDS;

	// Pattern codes as stored in the pattern table.
	localparam logic [3:0] PAT_OFF          = 4'd0;
	localparam logic [3:0] PAT_RED          = 4'd1;
	localparam logic [3:0] PAT_GREEN        = 4'd2;
	localparam logic [3:0] PAT_YELLOW       = 4'd3;
	localparam logic [3:0] PAT_RED_SLOW     = 4'd4;
	localparam logic [3:0] PAT_RED_FAST     = 4'd5;
	localparam logic [3:0] PAT_GREEN_FAST   = 4'd6;
	localparam logic [3:0] PAT_GREEN_SLOW   = 4'd7;
	localparam logic [3:0] PAT_YELLOW_SLOW  = 4'd8;
	localparam logic [3:0] PAT_YELLOW_FAST  = 4'd9;

	// Color codes of one slot.
	localparam logic [1:0] COLOR_OFF    = 2'd0;
	localparam logic [1:0] COLOR_RED    = 2'd1;
	localparam logic [1:0] COLOR_GREEN  = 2'd2;
	localparam logic [1:0] COLOR_YELLOW = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] CFG_FAST_ON     = 3'd0;
	localparam logic [2:0] CFG_FAST_PERIOD = 3'd1;
	localparam logic [2:0] CFG_SLOW_ON     = 3'd2;
	localparam logic [2:0] CFG_SLOW_PERIOD = 3'd3;
	localparam logic [2:0] CFG_REVERSE     = 3'd4;

	typedef struct packed {
		logic [3:0] fast_on_ticks;
		logic [3:0] fast_period;
		logic [3:0] slow_on_ticks;
		logic [3:0] slow_period;
		logic       reverse_order;
	} cfg_t;

	// Outcome of evaluating one LED on a tick.
	typedef struct packed {
		logic       slot_we;
		logic [1:0] color;
		logic [3:0] next_count;
	} led_upd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_EMIT
	} state_t;

endpackage

>>> rtl/core/mlbc_led_unit.sv
`timescale 1ns / 1ps

module mlbc_led_unit (
	input  logic [3:0]       pattern,
	input  logic [3:0]       count,
	input  mlbc_pkg::cfg_t   cfg,
	output mlbc_pkg::led_upd_t upd
);
	import mlbc_pkg::*;

	logic       blink;
	logic       use_slow;
	logic [1:0] blink_color;
	logic [3:0] on_ticks;
	logic [3:0] period;
	logic [4:0] count_inc;

	always_comb begin
		blink       = 1'b1;
		use_slow    = 1'b0;
		blink_color = COLOR_OFF;
		case (pattern)
			PAT_RED_SLOW: begin
				use_slow    = 1'b1;
				blink_color = COLOR_RED;
			end
			PAT_RED_FAST: begin
				blink_color = COLOR_RED;
			end
			PAT_GREEN_FAST: begin
				blink_color = COLOR_GREEN;
			end
			PAT_GREEN_SLOW: begin
				use_slow    = 1'b1;
				blink_color = COLOR_GREEN;
			end
			PAT_YELLOW_SLOW: begin
				use_slow    = 1'b1;
				blink_color = COLOR_YELLOW;
			end
			PAT_YELLOW_FAST: begin
				blink_color = COLOR_YELLOW;
			end
			default: begin
				blink = 1'b0;
			end
		endcase
	end

	assign on_ticks  = use_slow ? cfg.slow_on_ticks : cfg.fast_on_ticks;
	assign period    = use_slow ? cfg.slow_period : cfg.fast_period;
	assign count_inc = {1'b0, count} + 5'd1;

	always_comb begin
		upd.slot_we    = 1'b0;
		upd.color      = COLOR_OFF;
		upd.next_count = count;
		if (pattern inside {[PAT_OFF:PAT_YELLOW]}) begin
			upd.slot_we = 1'b1;
			upd.color   = pattern[1:0];
		end else if (blink) begin
			if (count < on_ticks) begin
				upd.slot_we = 1'b1;
				upd.color   = blink_color;
			end else if (count < period) begin
				upd.slot_we = 1'b1;
			end
			// The counter wraps to zero once it reaches the period.
			upd.next_count = (count_inc >= {1'b0, period}) ? 4'd0 : count_inc[3:0];
		end
	end

endmodule

>>> rtl/core/multi_led_blink_controller.sv
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// item      item_valid / item_stall   mode, led_index, pattern
// frame     frame_valid / frame_stall frame_bits
// config    cfg_we                    cfg_index, cfg_data
//
// A set beat is written straight into the pattern table.
// A tick walks the LEDs through one shared evaluation unit, one LED per cycle,
// and then loads the output register.
// Reset clears the pattern table, the blink counters, the color frame and the
// configuration to their power-up values at once; no clearing pass is needed.
// The frame waits in an output register; further set beats are taken while it
// waits, and a following tick holds in its emit state until the frame is taken.
module multi_led_blink_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        mode,
	input  logic [3:0]  led_index,
	input  logic [3:0]  pattern,
	output logic        frame_valid,
	input  logic        frame_stall,
	output logic [mlbc_pkg::FRAME_BITS-1:0] frame_bits,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [3:0]  cfg_data
);
	import mlbc_pkg::*;

	state_t state_q, state_d;

	cfg_t                 cfg_q;
	logic [3:0]           pattern_q [NUM_LEDS];
	logic [3:0]           count_q   [NUM_LEDS];
	logic [SLOT_BITS-1:0] color_frame_q;
	logic [LED_W-1:0]     walk_idx_q;
	logic [LED_W-1:0]     slot;
	logic                 frame_valid_q;
	logic [FRAME_BITS-1:0] frame_q;

	logic     accept;
	logic     set_we;
	logic     walk_en;
	logic     emit;
	logic     last_led;
	led_upd_t upd;

	assign accept   = item_valid && !item_stall;
	assign set_we   = accept && !mode && (led_index < 4'(NUM_LEDS));
	assign last_led = (walk_idx_q == LED_W'(NUM_LEDS - 1));

	// The slot order inside the frame follows the reverse_order register.
	assign slot = cfg_q.reverse_order ? walk_idx_q : LED_W'(NUM_LEDS - 1) - walk_idx_q;

	// The one evaluation unit shared by every LED of the walk.
	mlbc_led_unit u_led_unit (
		.pattern (pattern_q[walk_idx_q]),
		.count   (count_q[walk_idx_q]),
		.cfg     (cfg_q),
		.upd     (upd)
	);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && mode) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (last_led) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!frame_valid_q || !frame_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Output logic of the sequencer.
	always_comb begin
		item_stall = 1'b1;
		walk_en    = 1'b0;
		emit       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
			end
			ST_WALK: begin
				walk_en = 1'b1;
			end
			ST_EMIT: begin
				emit = !frame_valid_q || !frame_stall;
			end
			default: begin
				item_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fast_on_ticks <= 4'd1;
			cfg_q.fast_period   <= 4'd2;
			cfg_q.slow_on_ticks <= 4'd5;
			cfg_q.slow_period   <= 4'd10;
			cfg_q.reverse_order <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FAST_ON:     cfg_q.fast_on_ticks <= cfg_data;
				CFG_FAST_PERIOD: cfg_q.fast_period   <= cfg_data;
				CFG_SLOW_ON:     cfg_q.slow_on_ticks <= cfg_data;
				CFG_SLOW_PERIOD: cfg_q.slow_period   <= cfg_data;
				CFG_REVERSE:     cfg_q.reverse_order <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Walk index: it is zero whenever the sequencer idles.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_idx_q <= '0;
		end else if (walk_en) begin
			walk_idx_q <= last_led ? '0 : walk_idx_q + LED_W'(1);
		end
	end

	// Pattern table, blink counters and the color frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEDS; i++) begin
				pattern_q[i] <= PAT_OFF;
				count_q[i]   <= 4'd0;
			end
			color_frame_q <= '0;
		end else begin
			if (set_we) begin
				pattern_q[led_index[LED_W-1:0]] <= pattern;
			end
			if (walk_en) begin
				count_q[walk_idx_q] <= upd.next_count;
				if (upd.slot_we) begin
					color_frame_q[2*slot +: 2] <= upd.color;
				end
			end
		end
	end

	// Output register: the frame sits above four zero bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= 1'b0;
		end else if (emit) begin
			frame_valid_q <= 1'b1;
		end else if (!frame_stall) begin
			frame_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			frame_q <= FRAME_BITS'({color_frame_q, 4'b0000});
		end
	end

	assign frame_valid = frame_valid_q;
	assign frame_bits  = frame_q;

endmodule

>>> bench/multi_led_blink_controller_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the multi-LED blink controller.
// The stimulus code queues set and tick beats. A clocked driver plays them into
// the item channel with random gaps. A clocked monitor takes frames with random
// stalls and checks each one against a frame predicted when its tick was accepted.
module multi_led_blink_controller_tb;
	import mlbc_pkg::*;

	localparam int LATENCY  = NUM_LEDS + 6;  // one tick walk plus margin
	localparam int WATCHDOG = 2000;          // cycles with no beat on either channel
	localparam int PHASES   = 9;
	localparam int HOLD_OFF = 300;

	typedef struct {
		logic       mode;
		logic [3:0] led_index;
		logic [3:0] pattern;
	} beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic       item_valid = 1'b0;
	logic       item_stall;
	logic       mode = 1'b0;
	logic [3:0] led_index = 4'd0;
	logic [3:0] pattern = 4'd0;
	logic       frame_valid;
	logic       frame_stall = 1'b0;
	logic [FRAME_BITS-1:0] frame_bits;
	logic       cfg_we = 1'b0;
	logic [2:0] cfg_index = CFG_FAST_ON;
	logic [3:0] cfg_data = 4'd0;

	// Shadow copy of the block: configuration, per-LED pattern and counter, and
	// the two-bit color slots.
	cfg_t knobs = '{fast_on_ticks: 4'd1, fast_period: 4'd2, slow_on_ticks: 4'd5,
		slow_period: 4'd10, reverse_order: 1'b0};
	logic [3:0] led_pattern [NUM_LEDS] = '{default: PAT_OFF};
	logic [3:0] blink_count [NUM_LEDS] = '{default: 4'd0};
	logic [SLOT_BITS-1:0] shade = '0;

	beat_t pending [$];
	logic [FRAME_BITS-1:0] frames_due [$];

	int beats_queued = 0;
	int beats_taken = 0;
	int n_ticks = 0;
	int n_sets = 0;
	int frames_seen = 0;
	int errors = 0;
	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;
	int quiet = 0;
	bit held = 1'b0;
	bit sender_calm = 1'b0;
	bit receiver_calm = 1'b0;

	multi_led_blink_controller DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.mode       (mode),
		.led_index  (led_index),
		.pattern    (pattern),
		.frame_valid(frame_valid),
		.frame_stall(frame_stall),
		.frame_bits (frame_bits),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	// Idle lengths: mostly none or short, now and then a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Advances the shadow state by one tick and returns the frame it produces.
	function automatic logic [FRAME_BITS-1:0] tick_frame();
		logic [3:0] on_t;
		logic [3:0] per;
		logic [3:0] cnt;
		logic [4:0] nxt;
		logic [1:0] hue;
		bit blink;
		int slot;
		for (int led = 0; led < NUM_LEDS; led++) begin
			slot = knobs.reverse_order ? led : NUM_LEDS - 1 - led;
			blink = 1'b1;
			hue = COLOR_OFF;
			on_t = 4'd0;
			per = 4'd0;
			case (led_pattern[led])
				PAT_OFF: begin
					shade[2*slot +: 2] = COLOR_OFF;
					blink = 1'b0;
				end
				PAT_RED: begin
					shade[2*slot +: 2] = COLOR_RED;
					blink = 1'b0;
				end
				PAT_GREEN: begin
					shade[2*slot +: 2] = COLOR_GREEN;
					blink = 1'b0;
				end
				PAT_YELLOW: begin
					shade[2*slot +: 2] = COLOR_YELLOW;
					blink = 1'b0;
				end
				PAT_RED_SLOW: begin
					hue = COLOR_RED;
					on_t = knobs.slow_on_ticks;
					per = knobs.slow_period;
				end
				PAT_RED_FAST: begin
					hue = COLOR_RED;
					on_t = knobs.fast_on_ticks;
					per = knobs.fast_period;
				end
				PAT_GREEN_FAST: begin
					hue = COLOR_GREEN;
					on_t = knobs.fast_on_ticks;
					per = knobs.fast_period;
				end
				PAT_GREEN_SLOW: begin
					hue = COLOR_GREEN;
					on_t = knobs.slow_on_ticks;
					per = knobs.slow_period;
				end
				PAT_YELLOW_SLOW: begin
					hue = COLOR_YELLOW;
					on_t = knobs.slow_on_ticks;
					per = knobs.slow_period;
				end
				PAT_YELLOW_FAST: begin
					hue = COLOR_YELLOW;
					on_t = knobs.fast_on_ticks;
					per = knobs.fast_period;
				end
				// Codes above the known set leave both the slot and the counter alone.
				default: blink = 1'b0;
			endcase
			if (blink) begin
				cnt = blink_count[led];
				// Lit while below the on time, dark while below the period, and
				// untouched once the counter is at or past the period.
				if (cnt < on_t)
					shade[2*slot +: 2] = hue;
				else if (cnt < per)
					shade[2*slot +: 2] = COLOR_OFF;
				nxt = {1'b0, cnt} + 5'd1;
				blink_count[led] = (nxt >= {1'b0, per}) ? 4'd0 : nxt[3:0];
			end
		end
		return FRAME_BITS'({shade, 4'b0000});
	endfunction

	function automatic void queue_beat(input logic m, input logic [3:0] idx,
		input logic [3:0] pat);
		beat_t b;
		b.mode = m;
		b.led_index = idx;
		b.pattern = pat;
		pending.push_back(b);
		beats_queued++;
	endfunction

	// The shadow copy follows a register write, which is safe because writes
	// only happen while the block is idle.
	task automatic write_reg(input logic [2:0] idx, input logic [3:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_FAST_ON:     knobs.fast_on_ticks = val;
			CFG_FAST_PERIOD: knobs.fast_period = val;
			CFG_SLOW_ON:     knobs.slow_on_ticks = val;
			CFG_SLOW_PERIOD: knobs.slow_period = val;
			CFG_REVERSE:     knobs.reverse_order = val[0];
			default: ;
		endcase
	endtask

	// Waits until every queued beat is taken and every frame has come back, then
	// lets a trailing set beat settle inside the block.
	task automatic drain();
		wait (beats_taken == beats_queued && frames_due.size() == 0);
		repeat (LATENCY) @(posedge clk);
	endtask

	// Driver. A beat is taken at an edge where valid is high and stall is low;
	// the prediction is made right there, from the payload that was on the wires.
	// A stalled beat is held unchanged. After each beat a random gap may follow.
	always @(posedge clk) begin : sender
		beat_t nb;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				if (mode) begin
					frames_due.push_back(tick_frame());
					n_ticks++;
				end else begin
					// Out-of-range indexes are dropped; the counter is not cleared.
					if (led_index < NUM_LEDS)
						led_pattern[led_index] = pattern;
					n_sets++;
				end
				beats_taken++;
			end
			if (!item_valid || !item_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					item_valid <= 1'b0;
				end else if (pending.size() > 0) begin
					nb = pending.pop_front();
					mode <= nb.mode;
					led_index <= nb.led_index;
					pattern <= nb.pattern;
					item_valid <= 1'b1;
					send_gap = sender_calm ? 0 : idle_len();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor. Each frame is compared with the oldest prediction. Once enough
	// frames have passed and the driver still has a long backlog, the receiver
	// stalls for a long stretch so that the output register fills and the block
	// stalls its item channel while the driver keeps offering beats.
	always @(posedge clk) begin : receiver
		logic [FRAME_BITS-1:0] want;
		if (arst_n) begin
			if (frame_valid && !frame_stall) begin
				frames_seen++;
				if (frames_due.size() == 0) begin
					$error("frame_bits: expected no frame, actual %h", frame_bits);
					errors++;
				end else begin
					want = frames_due.pop_front();
					if (frame_bits !== want) begin
						$error("frame_bits: expected %h, actual %h", want, frame_bits);
						errors++;
					end
				end
			end
			if (!held && frames_seen >= 20 && pending.size() > 20) begin
				held = 1'b1;
				hold_left = HOLD_OFF;
			end
			if (hold_left > 0) begin
				hold_left--;
				frame_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				frame_stall <= 1'b1;
			end else begin
				frame_stall <= 1'b0;
				if (!receiver_calm)
					stall_left = idle_len();
			end
		end
	end

	// Watchdog: ends the run if neither channel moves a beat for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (frame_valid && !frame_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet == WATCHDOG) begin
				$display("watchdog: no beat for %0d cycles, %0d frames still due",
					WATCHDOG, frames_due.size());
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		int ph;
		int r;
		logic [3:0] fo;
		logic [3:0] fp;
		logic [3:0] so;
		logic [3:0] sp;
		logic rv;
		logic [3:0] idx;
		logic [3:0] pat;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (ph = 0; ph < PHASES; ph++) begin
			// Phase 0 runs on the reset values. Later phases first walk the
			// extremes: everything at maximum, every register zero (zero period and
			// zero on time), on time past the period with a zero slow period, and
			// a period of one. The rest take random values over the full fields.
			if (ph > 0) begin
				case (ph)
					1: begin fo = 4'd15; fp = 4'd15; so = 4'd15; sp = 4'd15; rv = 1'b1; end
					2: begin fo = 4'd0;  fp = 4'd0;  so = 4'd0;  sp = 4'd0;  rv = 1'b0; end
					3: begin fo = 4'd7;  fp = 4'd3;  so = 4'd1;  sp = 4'd0;  rv = 1'b1; end
					4: begin fo = 4'd0;  fp = 4'd1;  so = 4'd15; sp = 4'd1;  rv = 1'b0; end
					default: begin
						fo = 4'($urandom_range(0, 15));
						fp = 4'($urandom_range(0, 15));
						so = 4'($urandom_range(0, 15));
						sp = 4'($urandom_range(0, 15));
						rv = 1'($urandom_range(0, 1));
					end
				endcase
				write_reg(CFG_FAST_ON, fo);
				write_reg(CFG_FAST_PERIOD, fp);
				write_reg(CFG_SLOW_ON, so);
				write_reg(CFG_SLOW_PERIOD, sp);
				write_reg(CFG_REVERSE, {3'b000, rv});
			end

			// Some phases run one side or the other back to back, with no gaps.
			sender_calm = (ph % 3 == 1);
			receiver_calm = (ph % 4 == 2);

			if (ph == 0) begin
				// Every pattern code on its own LED, first LED to last.
				for (int led = 0; led < NUM_LEDS; led++)
					queue_beat(1'b0, led[3:0], led[3:0]);
				repeat (3) queue_beat(1'b1, 4'd0, 4'd0);
				// Out-of-range indexes must be dropped; unknown codes stick.
				queue_beat(1'b0, 4'd15, 4'd15);
				queue_beat(1'b0, 4'd10, PAT_RED_FAST);
				queue_beat(1'b0, 4'd3, 4'd12);
				queue_beat(1'b0, 4'd9, 4'd15);
				queue_beat(1'b1, 4'd15, 4'd15);
				queue_beat(1'b1, 4'd0, 4'd0);
			end

			// Random traffic: mostly in-range sets of known codes mixed with ticks,
			// plus some dropped indexes and unknown codes. Ticks carry random
			// don't-care payload.
			for (int n = 0; n < ((ph == 0) ? 30 : 45); n++) begin
				r = $urandom_range(0, 99);
				if (r < 40) begin
					queue_beat(1'b1, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
				end else begin
					idx = ($urandom_range(0, 9) < 9) ? 4'($urandom_range(0, NUM_LEDS - 1))
						: 4'($urandom_range(NUM_LEDS, 15));
					pat = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 9))
						: 4'($urandom_range(10, 15));
					queue_beat(1'b0, idx, pat);
				end
			end

			// The driver runs dry here and the bench waits for every frame, so the
			// next register writes land on an idle block.
			drain();
		end

		$display("covered %0d beats (%0d ticks, %0d sets) over %0d register settings",
			beats_taken, n_ticks, n_sets, PHASES);
		$display("checked %0d frames; long receiver hold-off %s", frames_seen,
			held ? "done" : "not reached");
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/mlbc_pkg.sv
rtl/core/mlbc_led_unit.sv
rtl/core/multi_led_blink_controller.sv
bench/multi_led_blink_controller_tb.sv
